### design/swtd_pkg.sv
package swtd_pkg;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_FRAME = 3'd1,
    KIND_MIC   = 3'd2,
    KIND_ACC_Z = 3'd3,
    KIND_TEMP  = 3'd4
  } kind_t;

  localparam int unsigned TICK_W  = 14;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TS_W    = 46;
  localparam int unsigned SMP_W   = 10;

  localparam logic [7:0] TAG_TOP_MASK = 8'hc0;
  localparam logic [7:0] TAG_TICK     = 8'hc0;
  localparam logic [7:0] TAG_MIC      = 8'h00;
  localparam logic [7:0] TAG_FRAME    = 8'h60;
  localparam logic [7:0] TAG_SUB_MASK = 8'hfc;
  localparam logic [7:0] TAG_ACC_X    = 8'h84;
  localparam logic [7:0] TAG_ACC_Y    = 8'h88;
  localparam logic [7:0] TAG_ACC_Z    = 8'h8c;
  localparam logic [7:0] TAG_TEMP     = 8'h40;

endpackage

### design/sensor_word_tag_decoder.sv
// Channel  Ports                                               Direction
// in       in_valid in_stall in_high_byte in_low_byte          word in
// out      out_valid out_stall out_kind out_sample out_timestamp  result out
//
// One word per cycle sustained while out_stall is not asserted.
// Stages: input register, then result register; tick state updates as
// a word leaves the input register.
// Reset (rst_n low, synchronous) empties both stages and zeroes tick and
// rollover count. out_stall backs up into in_stall in the same cycle.
module sensor_word_tag_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_high_byte,
  input  logic [7:0]                    in_low_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swtd_pkg::kind_t               out_kind,
  output logic [swtd_pkg::SMP_W-1:0]    out_sample,
  output logic [swtd_pkg::TS_W-1:0]     out_timestamp
);

  logic                              s1_valid_r;
  logic [7:0]                        s1_hb_r;
  logic [7:0]                        s1_lb_r;
  logic [swtd_pkg::TICK_W-1:0]       prev_tick_r;
  logic [swtd_pkg::TICK_W-1:0]       prev_tick_nxt;
  logic [swtd_pkg::COUNT_W-1:0]      count_r;
  logic [swtd_pkg::COUNT_W-1:0]      count_nxt;
  logic                              out_valid_r;
  swtd_pkg::kind_t                   kind_r;
  swtd_pkg::kind_t                   kind_nxt;
  logic [swtd_pkg::SMP_W-1:0]        sample_r;
  logic [swtd_pkg::SMP_W-1:0]        sample_nxt;
  logic [swtd_pkg::TS_W-1:0]         ts_r;
  logic [swtd_pkg::TS_W-1:0]         ts_nxt;
  logic                              has_result;
  logic                              out_free;
  logic                              s1_go;
  logic [swtd_pkg::TICK_W-1:0]       new_tick;
  logic [swtd_pkg::COUNT_W-1:0]      tick_count;
  logic [7:0]                        top;
  logic [7:0]                        sub;
  logic [swtd_pkg::TS_W-1:0]         ext_time;

  assign top      = s1_hb_r & swtd_pkg::TAG_TOP_MASK;
  assign sub      = s1_hb_r & swtd_pkg::TAG_SUB_MASK;
  assign new_tick = {s1_hb_r[5:0], s1_lb_r};
  assign ext_time = {count_r, prev_tick_r};
  assign tick_count = (new_tick < prev_tick_r) ? count_r + 1'b1 : count_r;

  always_comb begin
    has_result    = 1'b1;
    kind_nxt      = swtd_pkg::KIND_TICK;
    sample_nxt    = {s1_hb_r[1:0], s1_lb_r};
    ts_nxt        = ext_time;
    prev_tick_nxt = prev_tick_r;
    count_nxt     = count_r;
    if (top == swtd_pkg::TAG_TICK) begin
      prev_tick_nxt = new_tick;
      count_nxt     = tick_count;
      sample_nxt    = '0;
      ts_nxt        = {tick_count, new_tick};
    end else if (s1_hb_r == swtd_pkg::TAG_FRAME) begin
      kind_nxt   = swtd_pkg::KIND_FRAME;
      sample_nxt = '0;
      ts_nxt     = {{(swtd_pkg::TS_W - swtd_pkg::TICK_W - 8){1'b0}}, s1_lb_r, prev_tick_r};
    end else if (top == swtd_pkg::TAG_MIC) begin
      kind_nxt = swtd_pkg::KIND_MIC;
    end else if (sub == swtd_pkg::TAG_ACC_X || sub == swtd_pkg::TAG_ACC_Y) begin
      has_result = 1'b0;
    end else if (sub == swtd_pkg::TAG_ACC_Z) begin
      kind_nxt = swtd_pkg::KIND_ACC_Z;
    end else if (sub == swtd_pkg::TAG_TEMP) begin
      kind_nxt = swtd_pkg::KIND_TEMP;
      ts_nxt   = '0;
    end else begin
      has_result = 1'b0;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!has_result || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_tick_r <= '0;
      count_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        prev_tick_r <= prev_tick_nxt;
        count_r     <= count_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_go && has_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_hb_r <= in_high_byte;
      s1_lb_r <= in_low_byte;
    end
    if (out_free && s1_go && has_result) begin
      kind_r   <= kind_nxt;
      sample_r <= sample_nxt;
      ts_r     <= ts_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_sample    = sample_r;
  assign out_timestamp = ts_r;

endmodule
